### rtl/murmur3_byte_hash_macros.svh
// Assertion macros shared by the murmur3 byte hash RTL.
// Each macro samples on clk and is disabled while rst_n is low.
`ifndef MURMUR3_BYTE_HASH_MACROS_SVH
`define MURMUR3_BYTE_HASH_MACROS_SVH

// Same-cycle implication.
`define MBH_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define MBH_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/mbh_pkg.sv
// Package for the murmur3 byte hash: constants and controller/datapath structs.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package mbh_pkg;

  localparam int unsigned WORD_W = 32;
  localparam int unsigned CNT_W  = 3;

  localparam logic [WORD_W-1:0] MUL_C1     = 32'hcc9e2d51;
  localparam logic [WORD_W-1:0] MUL_C2     = 32'h1b873593;
  localparam logic [WORD_W-1:0] MIX_ADD    = 32'he6546b64;
  localparam logic [WORD_W-1:0] FIN_C1     = 32'h85ebca6b;
  localparam logic [WORD_W-1:0] FIN_C2     = 32'hc2b2ae35;
  localparam logic [WORD_W-1:0] SEED_RESET = 32'h1b873593;

  localparam logic [CNT_W-1:0] FULL_CNT = 3'd4;

  // controller -> datapath
  typedef struct packed {
    logic load;  // item accepted: first scramble product
    logic mix;   // second scramble product, fold into hash
    logic fin1;  // fold length, first avalanche product
    logic fin2;  // second avalanche product
    logic emit;  // finish avalanche into output register, rearm
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic last;      // current item is the last word of a key
    logic out_full;  // output register holds a result not taken this cycle
  } stat_t;

endpackage

`default_nettype wire

### rtl/mbh_ctrl.sv
// Controller state machine for the murmur3 byte hash.
// Depends on mbh_pkg and murmur3_byte_hash_macros.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "murmur3_byte_hash_macros.svh"

module mbh_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_tvalid,
  output logic               in_tready,
  input  wire mbh_pkg::stat_t stat,
  output mbh_pkg::cmd_t      cmd
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MIX  = 3'd1;
  localparam logic [2:0] S_FIN1 = 3'd2;
  localparam logic [2:0] S_FIN2 = 3'd3;
  localparam logic [2:0] S_FIN3 = 3'd4;

  logic [2:0] state_r, state_nxt;

  always_comb begin
    cmd       = '0;
    in_tready = 1'b0;
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          state_nxt = S_MIX;
        end
      end
      S_MIX: begin
        cmd.mix   = 1'b1;
        state_nxt = stat.last ? S_FIN1 : S_IDLE;
      end
      S_FIN1: begin
        cmd.fin1  = 1'b1;
        state_nxt = S_FIN2;
      end
      S_FIN2: begin
        cmd.fin2  = 1'b1;
        state_nxt = S_FIN3;
      end
      S_FIN3: begin
        // hold until the output register can take the result
        if (!stat.out_full) begin
          cmd.emit  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  `MBH_ASSERT_NXT(a_accept_mix, in_tvalid && in_tready, state_r == S_MIX, "accept not followed by mix")
  `MBH_ASSERT_NXT(a_stall_hold, state_r == S_FIN3 && stat.out_full, state_r == S_FIN3, "result dropped on stall")
  `MBH_ASSERT_IMP(a_emit_free, cmd.emit, !stat.out_full, "emit into full output register")

endmodule

`default_nettype wire

### rtl/mbh_dpath.sv
// Datapath for the murmur3 byte hash: seed, running hash, length, one shared
// 32x32 multiplier and the output register. Depends on mbh_pkg and the macros header.
`timescale 1ns / 1ps
`default_nettype none
`include "murmur3_byte_hash_macros.svh"

module mbh_dpath #(
  parameter logic [31:0] SEED_INIT = mbh_pkg::SEED_RESET
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        cfg_wr_en,
  input  wire logic [mbh_pkg::WORD_W-1:0]  cfg_wr_data,
  input  wire logic [mbh_pkg::WORD_W-1:0]  in_data_word,
  input  wire logic [mbh_pkg::CNT_W-1:0]   in_byte_count,
  input  wire logic                        in_last,
  input  wire mbh_pkg::cmd_t               cmd,
  output mbh_pkg::stat_t                   stat,
  input  wire logic                        out_tready,
  output logic                             out_tvalid,
  output logic [mbh_pkg::WORD_W-1:0]       out_hash
);

  logic [31:0] seed_r;
  logic [31:0] h_r, h_nxt;
  logic [31:0] total_r;
  logic        in_key_r;
  logic [31:0] prod_r;
  logic [2:0]  cnt_r;
  logic        last_r;
  logic        out_valid_r;
  logic [31:0] out_hash_r;

  logic [2:0]  cnt_sat;
  logic [31:0] tail_mask;
  logic [31:0] mul_a, mul_b, mul_p;
  logic [31:0] h_base, hx, hr, blk;
  logic [31:0] x0, x1, y;
  logic        is_block;

  assign cnt_sat = (in_byte_count > mbh_pkg::FULL_CNT) ? mbh_pkg::FULL_CNT : in_byte_count;

  // bytes beyond the count are dropped on a last word
  always_comb begin
    tail_mask = '1;
    if (in_last) begin
      unique case (cnt_sat)
        3'd0:    tail_mask = 32'h0000_0000;
        3'd1:    tail_mask = 32'h0000_00ff;
        3'd2:    tail_mask = 32'h0000_ffff;
        3'd3:    tail_mask = 32'h00ff_ffff;
        default: tail_mask = 32'hffff_ffff;
      endcase
    end
  end

  assign x0 = h_r ^ (total_r + {29'd0, cnt_r});
  assign x1 = x0 ^ (x0 >> 16);
  assign y  = prod_r ^ (prod_r >> 13);

  always_comb begin
    priority if (cmd.mix) begin
      mul_a = {prod_r[16:0], prod_r[31:17]};
      mul_b = mbh_pkg::MUL_C2;
    end else if (cmd.fin1) begin
      mul_a = x1;
      mul_b = mbh_pkg::FIN_C1;
    end else if (cmd.fin2) begin
      mul_a = y;
      mul_b = mbh_pkg::FIN_C2;
    end else begin
      mul_a = in_data_word & tail_mask;
      mul_b = mbh_pkg::MUL_C1;
    end
  end

  assign mul_p = mul_a * mul_b;

  assign h_base   = in_key_r ? h_r : seed_r;
  assign hx       = h_base ^ mul_p;
  assign hr       = {hx[18:0], hx[31:19]};
  assign blk      = (hr << 2) + hr + mbh_pkg::MIX_ADD;
  assign is_block = !last_r || (cnt_r == mbh_pkg::FULL_CNT);
  assign h_nxt    = is_block ? blk : hx;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seed_r      <= SEED_INIT;
      total_r     <= '0;
      in_key_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        seed_r <= cfg_wr_data;
      end
      if (cmd.mix) begin
        in_key_r <= 1'b1;
        if (!last_r) begin
          total_r <= total_r + 32'd4;
        end
      end
      if (cmd.emit) begin
        in_key_r <= 1'b0;
        total_r  <= '0;
      end
      out_valid_r <= cmd.emit || (out_valid_r && !out_tready);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cnt_r  <= cnt_sat;
      last_r <= in_last;
    end
    if (cmd.load || cmd.fin1 || cmd.fin2) begin
      prod_r <= mul_p;
    end
    if (cmd.mix) begin
      h_r <= h_nxt;
    end
    if (cmd.emit) begin
      out_hash_r <= prod_r ^ (prod_r >> 16);
    end
  end

  assign stat.last     = last_r;
  assign stat.out_full = out_valid_r && !out_tready;
  assign out_tvalid    = out_valid_r;
  assign out_hash      = out_hash_r;

  `MBH_ASSERT_NXT(a_emit_valid, cmd.emit, out_valid_r, "emitted result not presented")
  `MBH_ASSERT_NXT(a_emit_rearm, cmd.emit, !in_key_r && (total_r == 32'd0), "key state not rearmed")
  `MBH_ASSERT_IMP(a_cnt_range, cmd.mix, cnt_r <= mbh_pkg::FULL_CNT, "byte count not saturated")

endmodule

`default_nettype wire

### rtl/murmur3_byte_hash.sv
// Murmur3 byte hash, top level: seed register port, input and result streams.
// Depends on mbh_pkg, mbh_ctrl and mbh_dpath.
//
// Usage:
//   in_*  : key words, little endian. in_tdata = {byte_count[2:0], data_word[31:0]}
//           zero-padded to 40 bits; in_tlast marks the final word of a key,
//           whose byte_count (0..4, 5..7 act as 4) gives its valid bytes.
//   out_* : one 32-bit hash per key, in out_tdata.
//   cfg_* : seed write, takes effect at the start of the next key.
// Timing:
//   A non-last word is accepted, then scrambled and mixed; one 32x32
//   multiplier is shared for both scramble products.
//   A last word goes through accept, mix, two avalanche multiplies, finish.
//   The hash is valid in the cycle after the finish step and stays until taken.
// Stall: the output register holds the result; the next key's words are still
//   accepted, and only a following key's finish step waits for the register.
// Reset (synchronous, rst_n low): seed returns to its default, the length
//   count and key state clear, any pending result is dropped.
`timescale 1ns / 1ps
`default_nettype none

module murmur3_byte_hash #(
  parameter logic [31:0] SEED_INIT = mbh_pkg::SEED_RESET
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_wr_en,
  input  wire logic [31:0] cfg_wr_data,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [39:0] in_tdata,   // [31:0] data_word, [34:32] byte_count, rest zero
  input  wire logic        in_tlast,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [31:0]      out_tdata   // [31:0] hash_value
);

  mbh_pkg::cmd_t  cmd;
  mbh_pkg::stat_t stat;

  mbh_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  mbh_dpath #(
    .SEED_INIT (SEED_INIT)
  ) u_dpath (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .in_data_word  (in_tdata[31:0]),
    .in_byte_count (in_tdata[34:32]),
    .in_last       (in_tlast),
    .cmd           (cmd),
    .stat          (stat),
    .out_tready    (out_tready),
    .out_tvalid    (out_tvalid),
    .out_hash      (out_tdata)
  );

endmodule

`default_nettype wire

### sim/tb_top.sv
// Self-checking testbench for murmur3_byte_hash: directed table plus random keys.
// Holds its own murmur3 predictor; needs only the RTL (murmur3_byte_hash, mbh_ctrl, mbh_dpath and mbh_pkg).
`timescale 1ns / 1ps

module tb_top;

  localparam logic [31:0] K_MUL1    = 32'hcc9e2d51;
  localparam logic [31:0] K_MUL2    = 32'h1b873593;
  localparam logic [31:0] K_MIXADD  = 32'he6546b64;
  localparam logic [31:0] K_FIN1    = 32'h85ebca6b;
  localparam logic [31:0] K_FIN2    = 32'hc2b2ae35;
  localparam logic [31:0] SEED_DEF  = 32'h1b873593;
  localparam int          SETTLE    = 8;       // margin for the finish path plus output reg
  localparam int          CYCLE_CAP = 400000;
  localparam int          N_DIR     = 21;
  localparam int          PHASE_WORDS = 534;

  typedef enum logic {ROW_SEED, ROW_WORD} row_kind_t;

  typedef struct {
    row_kind_t   kind;
    logic [31:0] word;     // seed value on ROW_SEED rows
    logic [2:0]  cnt;
    logic        last;
    logic        has_ref;  // hash typed in below
    logic [31:0] ref_hash;
  } dir_row_t;

  dir_row_t dir_rows [N_DIR] = '{
    // reset seed
    '{ROW_WORD, 32'hdeadbeef, 3'd0, 1'b1, 1'b0, 32'h0},  // empty key, junk bytes
    '{ROW_WORD, 32'hffffff80, 3'd1, 1'b1, 1'b0, 32'h0},
    '{ROW_WORD, 32'h12345678, 3'd2, 1'b1, 1'b0, 32'h0},
    '{ROW_WORD, 32'hffffffff, 3'd3, 1'b1, 1'b0, 32'h0},
    '{ROW_WORD, 32'h00000000, 3'd4, 1'b1, 1'b0, 32'h0},
    '{ROW_WORD, 32'hffffffff, 3'd5, 1'b1, 1'b0, 32'h0},  // saturates to full block
    '{ROW_WORD, 32'h80000001, 3'd7, 1'b1, 1'b0, 32'h0},
    '{ROW_WORD, 32'hffffffff, 3'd3, 1'b0, 1'b0, 32'h0},  // count ignored mid-key
    '{ROW_WORD, 32'h00000000, 3'd7, 1'b0, 1'b0, 32'h0},
    '{ROW_WORD, 32'ha5a5a5a5, 3'd2, 1'b1, 1'b0, 32'h0},
    // zero seed: empty key hashes to zero regardless of the word
    '{ROW_SEED, 32'h00000000, 3'd0, 1'b0, 1'b0, 32'h0},
    '{ROW_WORD, 32'h00000000, 3'd0, 1'b1, 1'b1, 32'h0},
    '{ROW_WORD, 32'hffffffff, 3'd0, 1'b1, 1'b1, 32'h0},
    '{ROW_SEED, 32'hffffffff, 3'd0, 1'b0, 1'b0, 32'h0},
    '{ROW_WORD, 32'h01234567, 3'd6, 1'b0, 1'b0, 32'h0},
    '{ROW_WORD, 32'hfedcba98, 3'd6, 1'b1, 1'b0, 32'h0},
    '{ROW_WORD, 32'h00ffffff, 3'd3, 1'b1, 1'b0, 32'h0},
    '{ROW_WORD, 32'hffffffff, 3'd4, 1'b1, 1'b0, 32'h0},
    '{ROW_WORD, 32'hffffffff, 3'd0, 1'b0, 1'b0, 32'h0},
    '{ROW_WORD, 32'h7fffffff, 3'd4, 1'b0, 1'b0, 32'h0},
    '{ROW_WORD, 32'h80000000, 3'd1, 1'b1, 1'b0, 32'h0}
  };

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_wr_en = 1'b0;
  logic [31:0] cfg_wr_data = '0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [39:0] in_tdata = '0;    // [31:0] data_word, [34:32] byte_count, rest zero
  logic        in_tlast = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;        // [31:0] hash_value

  // predictor state
  logic [31:0] seed_val = SEED_DEF;
  logic [31:0] hash_acc = SEED_DEF;
  logic [31:0] len_acc = '0;
  logic        key_open = 1'b0;
  logic [31:0] hash_q[$];

  // typed-in hash for the directed item being driven
  logic        row_has_ref = 1'b0;
  logic [31:0] row_ref_hash = '0;

  int in_gap_pct = 0;
  int out_gap_pct = 0;
  int cycle_cnt = 0;
  int err_cnt = 0;
  int words_sent = 0;
  int hashes_seen = 0;
  int seed_writes = 0;

  murmur3_byte_hash DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always #5 clk = ~clk;

  always @(posedge clk) cycle_cnt <= cycle_cnt + 1;

  always @(negedge clk) out_tready <= ($urandom_range(99) >= out_gap_pct);

  function automatic logic [31:0] rotl(input logic [31:0] v, input int r);
    return (v << r) | (v >> (32 - r));
  endfunction

  function automatic logic [31:0] scramble(input logic [31:0] k);
    logic [31:0] t;
    t = k * K_MUL1;
    t = rotl(t, 15);
    return t * K_MUL2;
  endfunction

  function automatic logic [31:0] mix_block(input logic [31:0] h, input logic [31:0] k);
    logic [31:0] t;
    t = rotl(h ^ scramble(k), 13);
    return t * 32'd5 + K_MIXADD;
  endfunction

  function automatic logic [31:0] avalanche(input logic [31:0] h);
    logic [31:0] t;
    t = h ^ (h >> 16);
    t = t * K_FIN1;
    t = t ^ (t >> 13);
    t = t * K_FIN2;
    return t ^ (t >> 16);
  endfunction

  task automatic predict_word(input logic [31:0] w, input logic [2:0] c, input logic l);
    logic [31:0] h;
    logic [2:0]  n;
    h = key_open ? hash_acc : seed_val;
    if (!l) begin
      hash_acc = mix_block(h, w);
      len_acc  = len_acc + 32'd4;
      key_open = 1'b1;
    end else begin
      n = (c > 3'd4) ? 3'd4 : c;
      if (n == 3'd4) begin
        h = mix_block(h, w);
      end else if (n != 3'd0) begin
        h = h ^ scramble(w & ((32'd1 << (8 * n)) - 32'd1));
      end
      h = h ^ (len_acc + 32'(n));
      hash_q.push_back(row_has_ref ? row_ref_hash : avalanche(h));
      hash_acc = seed_val;
      len_acc  = '0;
      key_open = 1'b0;
    end
  endtask

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    err_cnt++;
    $display("ERROR %s: got %08h expected %08h (cycle %0d)", what, got, want, cycle_cnt);
  endtask

  // result check first, then the prediction for an item taken on the same edge
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        hashes_seen++;
        if (hash_q.size() == 0)
          report_mismatch("unexpected hash", out_tdata, 32'h0);
        else if (out_tdata !== hash_q[0])
          report_mismatch("hash_value", out_tdata, hash_q.pop_front());
        else
          void'(hash_q.pop_front());
      end
      if (cfg_wr_en) begin
        seed_val = cfg_wr_data;
        if (!key_open) hash_acc = cfg_wr_data;
      end
      if (in_tvalid && in_tready)
        predict_word(in_tdata[31:0], in_tdata[34:32], in_tlast);
    end
  end

  task automatic push_word(input logic [31:0] w, input logic [2:0] c, input logic l);
    @(negedge clk);
    while ($urandom_range(99) < in_gap_pct) begin
      in_tvalid = 1'b0;
      @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tdata  = {5'b0, c, w};
    in_tlast  = l;
    do @(posedge clk); while (!in_tready);
    words_sent++;
  endtask

  // seed changes only once every hash is out and the pipeline has gone quiet
  task automatic write_seed(input logic [31:0] v);
    @(negedge clk);
    in_tvalid = 1'b0;
    while (hash_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    @(negedge clk);
    cfg_wr_en   = 1'b1;
    cfg_wr_data = v;
    @(negedge clk);
    cfg_wr_en = 1'b0;
    seed_writes++;
  endtask

  task automatic run_phase(input int n_words, input int in_pct, input int out_pct,
                           input logic [31:0] seed);
    int          start;
    int          len;
    logic [31:0] w;
    write_seed(seed);
    in_gap_pct  = in_pct;
    out_gap_pct = out_pct;
    row_has_ref = 1'b0;
    start = words_sent;
    while (words_sent - start < n_words) begin
      len = ($urandom_range(19) == 0) ? $urandom_range(60, 20) : $urandom_range(5, 0);
      for (int i = 0; i <= len; i++) begin
        w = $urandom;
        if ($urandom_range(9) == 0) w = ($urandom_range(1) != 0) ? 32'hffffffff : 32'h0;
        push_word(w, 3'($urandom_range(7)), i == len);
      end
    end
  endtask

  initial begin
    wait (cycle_cnt >= CYCLE_CAP);
    $display("timeout after %0d cycles, %0d hashes still due", cycle_cnt, hash_q.size());
    $display("tb_top: FAIL");
    $finish;
  end

  initial begin
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    for (int r = 0; r < N_DIR; r++) begin
      if (dir_rows[r].kind == ROW_SEED) begin
        write_seed(dir_rows[r].word);
      end else begin
        // settles after the predictor has seen the previous row's item
        row_has_ref  <= dir_rows[r].has_ref;
        row_ref_hash <= dir_rows[r].ref_hash;
        push_word(dir_rows[r].word, dir_rows[r].cnt, dir_rows[r].last);
      end
    end

    run_phase(PHASE_WORDS, 36, 48, $urandom);
    run_phase(PHASE_WORDS, 48, 36, 32'hffffffff);
    run_phase(PHASE_WORDS, 0, 0, $urandom);

    @(negedge clk);
    in_tvalid = 1'b0;
    while (hash_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);

    $display("covered %0d key words and %0d finished hashes across %0d seed values,",
             words_sent, hashes_seen, seed_writes + 1);
    $display("tail lengths 0 to 7, long keys, and three sender/receiver stall profiles");
    if (err_cnt == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("%0d mismatches", err_cnt);
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule
